// ----- rtl/cse_pkg.sv -----
package cse_pkg;

    // Key and count widths.
    localparam int KEY_W     = 10;
    localparam int KEY_RANGE = 1 << KEY_W;
    localparam int MAX_ITEMS = 4096;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    // Request type codes.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Input request payload.
    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key;
    } t_req;

    // Result payload.
    typedef struct packed {
        logic [KEY_W-1:0] key_out;
        logic             valid_res;
        logic             last;
        logic             dropped;
    } t_res;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;      // write zero at the sweep pointer and advance it
        logic acc_load;    // request accepted as a load: read the count of its key
        logic acc_read;    // request accepted as a read: read at the scan floor
        logic scan_step;   // read the next key of the scan
        logic load_wr;     // store count plus one and answer the load
        logic take_wr;     // store count minus one and answer the read with the key
        logic resp_drop;   // answer a refused load
        logic resp_empty;  // answer a read on an empty store
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic empty;
        logic full;
        logic found;
        logic out_free;
    } t_stat;

endpackage

// ----- rtl/counting_sort_engine_unit.sv -----
// Channel   Payload  Valid        Ready        Direction
// request   i_req    i_in_valid   o_in_ready   in
// result    o_res    o_out_valid  i_out_ready  out
//
// A load reads the count of its key on acceptance, then writes the count plus one.
// A read reads at the scan floor on acceptance, then steps over zero-count keys
// with the single count memory port; the scan starts at the lowest key that may hold
// a count, so the keys stepped over in a drain number at most the key range.
// A refused load or a read on an empty store reads no count and only answers.
// After reset a clearing pass zeroes every entry of the count memory; no request
// is accepted meanwhile. A stalled result holds the next result back in its state.
module counting_sort_engine_unit
    import cse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_req,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_res o_res
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer for the clearing pass, loads and scans.
    cse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req.req_type),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Count memory, bookkeeping and result register.
    cse_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_key       (i_req.key),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_res       (o_res)
    );

endmodule

// ----- rtl/cse_ctrl.sv -----
module cse_ctrl
    import cse_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_req_type,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DROP  = 3'd4;
    localparam logic [2:0] S_EMPTY = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // A request is taken only while idle.
    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_req_type == REQ_LOAD) begin
                        if (i_stat.full) begin
                            n_state = S_DROP;
                        end else begin
                            o_cmd.acc_load = 1'b1;
                            n_state        = S_LOAD;
                        end
                    end else begin
                        if (i_stat.empty) begin
                            n_state = S_EMPTY;
                        end else begin
                            o_cmd.acc_read = 1'b1;
                            n_state        = S_SCAN;
                        end
                    end
                end
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load_wr = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_stat.found) begin
                    if (i_stat.out_free) begin
                        o_cmd.take_wr = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_DROP: begin
                if (i_stat.out_free) begin
                    o_cmd.resp_drop = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_EMPTY: begin
                if (i_stat.out_free) begin
                    o_cmd.resp_empty = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/cse_datapath.sv -----
module cse_datapath
    import cse_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [KEY_W-1:0] i_key,
    input  logic             i_out_ready,
    output t_stat            o_stat,
    output logic             o_out_valid,
    output t_res             o_res
);

    logic [CNT_W-1:0] r_mem [KEY_RANGE];
    logic [CNT_W-1:0] r_rdata;
    logic [KEY_W-1:0] r_rd_key;
    logic [KEY_W-1:0] r_ptr;
    logic [KEY_W-1:0] r_min;
    logic [KEY_W-1:0] r_largest;
    logic [CNT_W-1:0] r_total;
    logic             r_out_valid;
    t_res             r_res;

    logic             rd_en;
    logic [KEY_W-1:0] rd_addr;
    logic             wr_en;
    logic [KEY_W-1:0] wr_addr;
    logic [CNT_W-1:0] wr_data;
    logic             emit;
    logic             fin;

    // Read address: the load key, the scan floor, or the running scan pointer.
    assign rd_en = i_cmd.acc_load | i_cmd.acc_read | i_cmd.scan_step;
    always_comb begin
        priority if (i_cmd.acc_load) begin
            rd_addr = i_key;
        end else if (i_cmd.acc_read) begin
            rd_addr = r_min;
        end else begin
            rd_addr = r_ptr;
        end
    end

    // Write port: clearing sweep, increment on load, decrement on read.
    assign wr_en   = i_cmd.clr_wr | i_cmd.load_wr | i_cmd.take_wr;
    assign wr_addr = i_cmd.clr_wr ? r_ptr : r_rd_key;
    always_comb begin
        priority if (i_cmd.clr_wr) begin
            wr_data = '0;
        end else if (i_cmd.load_wr) begin
            wr_data = r_rdata + CNT_W'(1);
        end else begin
            wr_data = r_rdata - CNT_W'(1);
        end
    end

    // Count memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata  <= r_mem[rd_addr];
            r_rd_key <= rd_addr;
        end
    end

    // Sweep and scan pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_cmd.acc_read) begin
            r_ptr <= r_min + KEY_W'(1);
        end else if (i_cmd.clr_wr || i_cmd.scan_step) begin
            r_ptr <= r_ptr + KEY_W'(1);
        end
    end

    // The read that empties the store is the one taken while one item is held.
    assign fin = (r_total == CNT_W'(1));

    // Bookkeeping: total held, largest key, and the floor below which all
    // counts are zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_largest <= '0;
            r_min     <= '0;
        end else if (i_cmd.load_wr) begin
            r_total <= r_total + CNT_W'(1);
            if (r_rd_key > r_largest) begin
                r_largest <= r_rd_key;
            end
            if (r_rd_key < r_min) begin
                r_min <= r_rd_key;
            end
        end else if (i_cmd.take_wr) begin
            r_total <= r_total - CNT_W'(1);
            r_min   <= r_rd_key;
            if (fin) begin
                r_largest <= '0;
            end
        end
    end

    // Output register.
    assign emit = i_cmd.load_wr | i_cmd.take_wr | i_cmd.resp_drop | i_cmd.resp_empty;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_res.key_out   <= i_cmd.take_wr ? r_rd_key : '0;
            r_res.valid_res <= i_cmd.take_wr;
            r_res.last      <= i_cmd.take_wr & fin;
            r_res.dropped   <= i_cmd.resp_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    // Status back to the controller.
    assign o_stat.clear_done = (r_ptr == KEY_W'(KEY_RANGE - 1));
    assign o_stat.empty      = (r_total == '0);
    assign o_stat.full       = (r_total >= CNT_W'(MAX_ITEMS));
    assign o_stat.found      = (r_rdata != '0);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

`ifndef NO_ASSERTIONS
    // A new result never overwrites one still waiting to be taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // The held total never exceeds capacity.
    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(MAX_ITEMS))
        else $error("total exceeds capacity");

    // A read takes from a nonzero count no higher than the largest key.
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_wr |-> (r_rdata != '0 && r_rd_key <= r_largest))
        else $error("read took an empty or out-of-bound entry");

    // Emptying the store returns the largest key to zero.
    a_drain_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take_wr && fin) |=> (r_largest == '0 && r_total == '0))
        else $error("store drained without clearing largest key");
`endif

endmodule
